/* design/lrs_pkg.sv */
// Package: payload word types shared by the sorter's top level and its testbench.
package lrs_pkg;

   localparam int KEY_W = 31;

   typedef logic [KEY_W-1:0] lrs_key_type;

   typedef struct packed {
      lrs_key_type key;
      logic        last_key;
   } lrs_req_type;

   typedef struct packed {
      lrs_key_type sorted_key;
      logic        last_out;
   } lrs_rsp_type;

endpackage

/* design/lrs_cell.sv */
// One cell of the sorting chain: holds one key, passes the larger key to the right.
module lrs_cell #(
   parameter int KW = 31
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          shift,
   input  logic          cin_valid,
   input  logic [KW-1:0] cin_key,
   input  logic          nbr_valid,
   input  logic [KW-1:0] nbr_key,
   output logic          hold_valid,
   output logic [KW-1:0] hold_key,
   output logic          cout_valid,
   output logic [KW-1:0] cout_key
);

   logic          hold_valid_ff, hold_valid_in;
   logic [KW-1:0] hold_key_ff, hold_key_in;
   logic          cout_valid_ff, cout_valid_in;
   logic [KW-1:0] cout_key_ff, cout_key_in;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_key_in   = hold_key_ff;
      cout_valid_in = 1'b0;
      cout_key_in   = cout_key_ff;
      if (shift) begin
         // drain: take the right neighbour's key
         hold_valid_in = nbr_valid;
         hold_key_in   = nbr_key;
      end else if (cin_valid) begin
         if (!hold_valid_ff) begin
            hold_valid_in = 1'b1;
            hold_key_in   = cin_key;
         end else if (cin_key < hold_key_ff) begin
            hold_key_in   = cin_key;
            cout_valid_in = 1'b1;
            cout_key_in   = hold_key_ff;
         end else begin
            cout_valid_in = 1'b1;
            cout_key_in   = cin_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         cout_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         cout_valid_ff <= cout_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_key_ff <= hold_key_in;
      cout_key_ff <= cout_key_in;
   end

   assign hold_valid = hold_valid_ff;
   assign hold_key   = hold_key_ff;
   assign cout_valid = cout_valid_ff;
   assign cout_key   = cout_key_ff;

endmodule

/* design/lsd_radix_sort.sv */
// Top level: key sorter built from a chain of insertion cells.
//
//   channel  direction  handshake              word
//   req      in         req_valid / req_ready  lrs_req_type (key, last_key)
//   rsp      out        rsp_valid / rsp_ready  lrs_rsp_type (sorted_key, last_out)
//
// Load: one word per cycle; each key enters cell 0 and ripples right one cell a cycle.
// After the last word the chain settles in ST_SETTLE until every key reaches its cell,
// then emits one word per cycle from cell 0 while rsp_ready is high, the whole chain
// shifting left on each accept.
// Reset clears the state, the key count and every cell's valid bit.
// rsp_ready low holds the chain; req_ready is high only while loading.
module lsd_radix_sort #(
   parameter int MAX_ITEMS = 64,
   parameter int KEY_BITS  = 31
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lrs_pkg::lrs_req_type req_word,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lrs_pkg::lrs_rsp_type rsp_word
);

   localparam int KW = (KEY_BITS < lrs_pkg::KEY_W) ? KEY_BITS : lrs_pkg::KEY_W;
   localparam int CW = $clog2(MAX_ITEMS + 1);

   localparam logic [1:0] ST_LOAD   = 2'd0;
   localparam logic [1:0] ST_SETTLE = 2'd1;
   localparam logic [1:0] ST_OUT    = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] settle_ff, settle_in;

   logic [MAX_ITEMS-1:0] hv;
   logic [KW-1:0]        hk [MAX_ITEMS];
   logic [MAX_ITEMS-1:0] nv;
   logic [KW-1:0]        nk [MAX_ITEMS];
   logic [MAX_ITEMS:0]   cv;
   logic [KW-1:0]        ck [MAX_ITEMS+1];

   logic insert;
   logic shift;

   assign req_ready = (state_ff == ST_LOAD);
   assign insert    = req_valid && req_ready && (count_ff < CW'(MAX_ITEMS));
   assign cv[0]     = insert;
   assign ck[0]     = req_word.key[KW-1:0];

   assign rsp_valid           = (state_ff == ST_OUT) && hv[0];
   assign rsp_word.sorted_key = lrs_pkg::lrs_key_type'(hk[0]);
   assign rsp_word.last_out   = ~hv[1];
   assign shift               = rsp_valid && rsp_ready;

   genvar i;
   generate
      for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
         if (i == MAX_ITEMS - 1) begin : g_end
            assign nv[i] = 1'b0;
            assign nk[i] = hk[i];
         end else begin : g_mid
            assign nv[i] = hv[i+1];
            assign nk[i] = hk[i+1];
         end
         lrs_cell #(.KW(KW)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift      (shift),
            .cin_valid  (cv[i]),
            .cin_key    (ck[i]),
            .nbr_valid  (nv[i]),
            .nbr_key    (nk[i]),
            .hold_valid (hv[i]),
            .hold_key   (hk[i]),
            .cout_valid (cv[i+1]),
            .cout_key   (ck[i+1])
         );
      end
   endgenerate

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      settle_in = settle_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (insert) begin
                  count_in = count_ff + 1'b1;
               end
               if (req_word.last_key) begin
                  // wait long enough for the last key to reach its cell
                  state_in  = ST_SETTLE;
                  settle_in = count_in;
                  count_in  = '0;
               end
            end
         end
         ST_SETTLE: begin
            if (settle_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               settle_in = settle_ff - 1'b1;
            end
         end
         ST_OUT: begin
            if (shift && rsp_word.last_out) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         count_ff  <= '0;
         settle_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         settle_ff <= settle_in;
      end
   end

`ifndef SYNTHESIS
   a_compact : assert property (@(posedge clock) disable iff (reset)
      ((hv & (hv + 1'b1)) == '0))
      else $error("sort chain has a gap");

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !cv[MAX_ITEMS])
      else $error("key carried off the end of the chain");

   a_settled : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (cv[MAX_ITEMS:1] == '0))
      else $error("keys still in flight while draining");

   a_ascending : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.last_out) |-> (hk[0] <= hk[1]))
      else $error("drain order not ascending");

   a_empty_after : assert property (@(posedge clock) disable iff (reset)
      (shift && rsp_word.last_out) |=> ((state_ff == ST_LOAD) && (hv == '0)))
      else $error("chain not empty after final word");
`endif

endmodule

/* verif/lsd_radix_sort_test.sv */
// Testbench for lsd_radix_sort: key sets in, ascending keys out, checked against a predictor.
`timescale 1ns / 100ps

module lsd_radix_sort_test;

   localparam int MAX_KEYS     = 64;
   localparam int DIGIT_BITS   = 3;
   localparam int BUCKETS      = 1 << DIGIT_BITS;
   localparam int RANDOM_ITEMS = 250;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 250;

   typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_WIDTH} key_spread_type;

   typedef struct {
      lrs_pkg::lrs_req_type word;
      bit                   typed;
      lrs_pkg::lrs_rsp_type result;
   } script_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   lrs_pkg::lrs_req_type req_word = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   lrs_pkg::lrs_rsp_type rsp_word;

   // predictor state: keys of the set being loaded and its largest key
   lrs_pkg::lrs_key_type set_keys[$];
   lrs_pkg::lrs_key_type set_top = '0;
   lrs_pkg::lrs_rsp_type sorted_due[$];
   script_row_type       script[$];

   int unsigned mismatches   = 0;
   int unsigned tx_idle_pct  = 0;
   int unsigned rx_idle_pct  = 0;
   logic        hold_off_req = 1'b0;
   int unsigned hold_left    = 0;
   bit          hold_done    = 1'b0;

   lsd_radix_sort dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Store the key (up to MAX_KEYS); on the last mark, sort the set by counting passes and, if asked, queue the output.
   function automatic void absorb_word(input lrs_pkg::lrs_req_type w, input bit queue_results);
      lrs_pkg::lrs_key_type ordered[MAX_KEYS];
      lrs_pkg::lrs_key_type spill[MAX_KEYS];
      int                   bucket_pos[BUCKETS];
      int                   n;
      int                   passes;
      int                   d;
      lrs_pkg::lrs_key_type rest;
      lrs_pkg::lrs_rsp_type r;
      if (set_keys.size() < MAX_KEYS) begin
         set_keys.push_back(w.key);
         if (w.key > set_top)
            set_top = w.key;
      end
      if (!w.last_key)
         return;
      n = set_keys.size();
      for (int i = 0; i < n; i++)
         ordered[i] = set_keys[i];
      passes = 1;
      rest = set_top >> DIGIT_BITS;
      while (rest != 0) begin
         passes++;
         rest = rest >> DIGIT_BITS;
      end
      for (int p = 0; p < passes; p++) begin
         for (int b = 0; b < BUCKETS; b++)
            bucket_pos[b] = 0;
         for (int i = 0; i < n; i++) begin
            d = int'((ordered[i] >> (p * DIGIT_BITS)) & (BUCKETS - 1));
            bucket_pos[d]++;
         end
         for (int b = 1; b < BUCKETS; b++)
            bucket_pos[b] += bucket_pos[b - 1];
         // scatter back to front to keep the pass stable
         for (int i = n - 1; i >= 0; i--) begin
            d = int'((ordered[i] >> (p * DIGIT_BITS)) & (BUCKETS - 1));
            bucket_pos[d]--;
            spill[bucket_pos[d]] = ordered[i];
         end
         for (int i = 0; i < n; i++)
            ordered[i] = spill[i];
      end
      if (queue_results) begin
         for (int i = 0; i < n; i++) begin
            r.sorted_key = ordered[i];
            r.last_out   = (i == n - 1);
            sorted_due.push_back(r);
         end
      end
      set_keys.delete();
      set_top = '0;
   endfunction

   function automatic lrs_pkg::lrs_key_type draw_key(input key_spread_type spread);
      case (spread)
         SPREAD_FULL:   return lrs_pkg::lrs_key_type'($urandom());
         SPREAD_NARROW: return lrs_pkg::lrs_key_type'($urandom_range(7, 0));
         default:       return lrs_pkg::lrs_key_type'($urandom() >> $urandom_range(31, 0));
      endcase
   endfunction

   task automatic add_row(input lrs_pkg::lrs_key_type k, input logic last, input bit typed,
                          input lrs_pkg::lrs_key_type result_key);
      script_row_type row;
      row.word.key          = k;
      row.word.last_key     = last;
      row.typed             = typed;
      row.result.sorted_key = result_key;
      row.result.last_out   = 1'b1;
      script.push_back(row);
   endtask

   // Offer one word, idling first at random; return at the edge that takes it.
   task automatic send_word(input lrs_pkg::lrs_req_type w);
      while ($urandom_range(99, 0) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_off_req && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (sorted_due.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual key %h last %b",
                     $time, rsp_word.sorted_key, rsp_word.last_out);
            mismatches++;
         end else begin
            if (rsp_word.sorted_key !== sorted_due[0].sorted_key) begin
               $display("%0t: sorted_key expected %h actual %h",
                        $time, sorted_due[0].sorted_key, rsp_word.sorted_key);
               mismatches++;
            end
            if (rsp_word.last_out !== sorted_due[0].last_out) begin
               $display("%0t: last_out expected %b actual %b",
                        $time, sorted_due[0].last_out, rsp_word.last_out);
               mismatches++;
            end
            void'(sorted_due.pop_front());
         end
      end
   end

   initial begin
      #1_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      lrs_pkg::lrs_req_type w;
      int                   set_no;
      int                   set_len;
      int                   random_items;
      key_spread_type       spread;

      // single-key sets: the key comes straight back
      add_row(31'h0000_0000, 1'b1, 1'b1, 31'h0000_0000);
      add_row(31'h7FFF_FFFF, 1'b1, 1'b1, 31'h7FFF_FFFF);
      // extremes and alternating bits
      add_row(31'h7FFF_FFFF, 1'b0, 1'b0, '0);
      add_row(31'h0000_0000, 1'b0, 1'b0, '0);
      add_row(31'h5555_5555, 1'b0, 1'b0, '0);
      add_row(31'h2AAA_AAAA, 1'b1, 1'b0, '0);
      // duplicates
      add_row(31'd3, 1'b0, 1'b0, '0);
      add_row(31'd3, 1'b0, 1'b0, '0);
      add_row(31'd3, 1'b1, 1'b0, '0);
      // one digit only: a single pass
      add_row(31'd7, 1'b0, 1'b0, '0);
      add_row(31'd0, 1'b0, 1'b0, '0);
      add_row(31'd5, 1'b0, 1'b0, '0);
      add_row(31'd1, 1'b0, 1'b0, '0);
      add_row(31'd6, 1'b1, 1'b0, '0);
      // mixed digit counts
      add_row(31'd8, 1'b0, 1'b0, '0);
      add_row(31'd1, 1'b0, 1'b0, '0);
      add_row(31'h4000_0000, 1'b0, 1'b0, '0);
      add_row(31'd9, 1'b0, 1'b0, '0);
      add_row(31'h0000_0040, 1'b1, 1'b0, '0);
      // last key smaller than the rest
      add_row(31'd1, 1'b0, 1'b0, '0);
      add_row(31'd0, 1'b1, 1'b0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      tx_idle_pct <= 13;
      rx_idle_pct <= 78;
      @(posedge clock);

      foreach (script[i]) begin
         send_word(script[i].word);
         if (script[i].typed) begin
            absorb_word(script[i].word, 1'b0);
            sorted_due.push_back(script[i].result);
         end else begin
            absorb_word(script[i].word, 1'b1);
         end
      end

      set_no = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= 2 * RANDOM_ITEMS / 3) begin
            tx_idle_pct <= 0;
            rx_idle_pct <= 0;
         end else if (random_items >= RANDOM_ITEMS / 3) begin
            tx_idle_pct <= 78;
            rx_idle_pct <= 13;
         end
         spread = key_spread_type'($urandom_range(2, 0));
         if (set_no == 0) begin
            // full set under a long receiver hold-off: fill the block, stall its input
            set_len = MAX_KEYS;
            hold_off_req <= 1'b1;
         end else if (set_no == 1) begin
            // overfull set: drop the extra keys, still sort on the last mark
            set_len = MAX_KEYS + $urandom_range(6, 1);
         end else if ($urandom_range(9, 0) == 0) begin
            set_len = MAX_KEYS;
         end else begin
            set_len = $urandom_range(12, 1);
         end
         // trim the final set to the word budget
         if (set_len > RANDOM_ITEMS - random_items)
            set_len = RANDOM_ITEMS - random_items;
         for (int i = 0; i < set_len; i++) begin
            w.key      = draw_key(spread);
            w.last_key = (i == set_len - 1);
            send_word(w);
            absorb_word(w, 1'b1);
            random_items++;
         end
         set_no++;
      end
      req_valid <= 1'b0;

      while (sorted_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && sorted_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* files.f */
design/lrs_pkg.sv
design/lrs_cell.sv
design/lsd_radix_sort.sv
verif/lsd_radix_sort_test.sv
